// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is held.
`define GHLP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Concurrent assertion that also holds across reset.
`define GHLP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== rtl/ghlp_pkg.sv =====
// Package: constants and types of the gzip header length parser.
`timescale 1ns / 1ps
package ghlp_pkg;

  localparam logic [7:0] MAGIC0     = 8'h1f;
  localparam logic [7:0] MAGIC1     = 8'h8b;
  localparam logic [7:0] F_EXTRA    = 8'h04;
  localparam logic [7:0] F_NAME     = 8'h08;
  localparam logic [7:0] F_COMMENT  = 8'h10;
  localparam logic [7:0] F_HCRC     = 8'h02;
  localparam int         FIXED_LEN  = 10;
  localparam int         FLAG_POS   = 4;
  localparam int         HLEN_W     = 16;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MAGIC = 2'd1,
    ST_TRUNC     = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_t;

  typedef struct packed {
    logic [HLEN_W-1:0] header_length;
    status_t           status;
  } result_t;

endpackage

// ===== rtl/ghlp_out_reg.sv =====
// Result register: holds one result until the receiver takes it.
`timescale 1ns / 1ps
module ghlp_out_reg
  import ghlp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  result_t             res,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [HLEN_W-1:0]   out_header_length,
  output logic [1:0]          out_status
);

  logic    valid_r;
  result_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid         = valid_r;
  assign out_header_length = res_r.header_length;
  assign out_status        = res_r.status;

endmodule

// ===== rtl/gzip_header_length_parser_top.sv =====
// Top level: gzip member header length parser.
// Usage:
//   Input channel in_valid/in_ready carries one buffer byte per request
//   (in_byte_value) with in_last_byte marking the buffer's final byte.
//   Output channel out_valid/out_ready carries at most one result per
//   buffer: out_header_length and out_status (ok, bad magic or short,
//   truncated, too long). Length is zero unless status is ok.
//   The result is registered: it shows in the cycle after the deciding byte.
//   Throughput: one byte per cycle while in_ready is high; the header
//   walk is held in registers updated from each byte; no byte waits on another.
//   A pending result does not stop input while out_ready is high; with
//   the result register full and out_ready low, in_ready drops until the
//   result is taken.
//   Bytes after the result are consumed and ignored until the last byte.
//   Reset (rst_n low, synchronous) empties the result register and sets
//   the parser to expect the first magic byte of a new buffer.
//   LENGTH_BITS sets the position counter; the header limit is
//   min(2^LENGTH_BITS - 1, 65535) bytes.
`timescale 1ns / 1ps
module gzip_header_length_parser_top
  import ghlp_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte_value,
  input  logic                in_last_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [HLEN_W-1:0]   out_header_length,
  output logic [1:0]          out_status
);

  localparam int PosW = (LENGTH_BITS < HLEN_W) ? LENGTH_BITS : HLEN_W;
  localparam logic [PosW-1:0] PosMax = '1;

  typedef enum logic [3:0] {
    PH_MAGIC0, PH_MAGIC1, PH_FIXED, PH_XLO, PH_XHI, PH_EXTRA,
    PH_NAME, PH_COMMENT, PH_CRC0, PH_CRC1, PH_DONE, PH_IGNORE
  } phase_t;

  phase_t         phase_r, phase_nxt, phase_step;
  logic [PosW-1:0] pos_r, pos_nxt, n;
  logic [7:0]     flags_r, flags_nxt;
  logic [15:0]    xrem_r, xrem_nxt;
  logic [7:0]     xlo_r, xlo_nxt;
  logic           accept;
  logic           bad;
  logic           fire;
  logic           active;
  result_t        res;

  function automatic phase_t next_part(input phase_t from, input logic [7:0] fl);
    phase_t p;
    if (from <= PH_XLO && (fl & F_EXTRA) != 8'd0) begin
      p = PH_XLO;
    end else if (from <= PH_NAME && (fl & F_NAME) != 8'd0) begin
      p = PH_NAME;
    end else if (from <= PH_COMMENT && (fl & F_COMMENT) != 8'd0) begin
      p = PH_COMMENT;
    end else if (from <= PH_CRC0 && (fl & F_HCRC) != 8'd0) begin
      p = PH_CRC0;
    end else begin
      p = PH_DONE;
    end
    return p;
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign n        = (pos_r == PosMax) ? PosMax : pos_r + 1'b1;

  always_comb begin
    phase_step = phase_r;
    flags_nxt  = flags_r;
    xrem_nxt   = xrem_r;
    xlo_nxt    = xlo_r;
    bad        = 1'b0;
    active     = 1'b1;
    unique case (phase_r)
      PH_MAGIC0: begin
        if (in_byte_value != MAGIC0) bad = 1'b1; else phase_step = PH_MAGIC1;
      end
      PH_MAGIC1: begin
        if (in_byte_value != MAGIC1) bad = 1'b1; else phase_step = PH_FIXED;
      end
      PH_FIXED: begin
        if (n == PosW'(FLAG_POS)) flags_nxt = in_byte_value;
        if (n >= PosW'(FIXED_LEN)) phase_step = next_part(PH_XLO, flags_r);
      end
      PH_XLO: begin
        xlo_nxt    = in_byte_value;
        phase_step = PH_XHI;
      end
      PH_XHI: begin
        xrem_nxt   = {in_byte_value, xlo_r};
        phase_step = ({in_byte_value, xlo_r} != 16'd0) ? PH_EXTRA
                                                        : next_part(PH_NAME, flags_r);
      end
      PH_EXTRA: begin
        xrem_nxt = xrem_r - 16'd1;
        if (xrem_r == 16'd1) phase_step = next_part(PH_NAME, flags_r);
      end
      PH_NAME: begin
        if (in_byte_value == 8'd0) phase_step = next_part(PH_COMMENT, flags_r);
      end
      PH_COMMENT: begin
        if (in_byte_value == 8'd0) phase_step = next_part(PH_CRC0, flags_r);
      end
      PH_CRC0: phase_step = PH_CRC1;
      PH_CRC1: phase_step = PH_DONE;
      default: begin
        phase_step = PH_IGNORE;
        active     = 1'b0;
      end
    endcase
  end

  always_comb begin
    fire              = 1'b0;
    res.header_length = '0;
    res.status        = ST_OK;
    if (active) begin
      priority if (bad) begin
        fire       = 1'b1;
        res.status = ST_BAD_MAGIC;
      end else if (phase_step == PH_DONE) begin
        fire              = 1'b1;
        res.header_length = HLEN_W'(n);
      end else if (n == PosMax) begin
        fire       = 1'b1;
        res.status = ST_TOO_LONG;
      end else if (in_last_byte) begin
        fire       = 1'b1;
        res.status = (n < PosW'(FIXED_LEN)) ? ST_BAD_MAGIC : ST_TRUNC;
      end else begin
        fire = 1'b0;
      end
    end
  end

  always_comb begin
    phase_nxt = fire ? PH_IGNORE : phase_step;
    pos_nxt   = active ? n : pos_r;
    if (in_last_byte) begin
      phase_nxt = PH_MAGIC0;
      pos_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC0;
      pos_r   <= '0;
      flags_r <= '0;
      xrem_r  <= '0;
      xlo_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      flags_r <= flags_nxt;
      xrem_r  <= xrem_nxt;
      xlo_r   <= xlo_nxt;
    end
  end

  ghlp_out_reg u_out_reg (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (accept && fire),
    .res               (res),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_header_length (out_header_length),
    .out_status        (out_status)
  );

endmodule

// ===== rtl/ghlp_checker.sv =====
// Port checker for the gzip header length parser, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ghlp_checker
  import ghlp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [7:0]          in_byte_value,
  input  logic                in_last_byte,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [HLEN_W-1:0]   out_header_length,
  input  logic [1:0]          out_status
);

  // held result keeps its payload
  `GHLP_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_header_length) && $stable(out_status))
  // length is only reported with an ok status
  `GHLP_ASSERT(a_len_zero, clk, rst_n, out_valid && out_status != ST_OK |-> out_header_length == '0)
  // an ok header covers at least the fixed part
  `GHLP_ASSERT(a_len_min, clk, rst_n, out_valid && out_status == ST_OK |-> out_header_length >= HLEN_W'(FIXED_LEN))
  // a stalled full result register blocks new requests
  `GHLP_ASSERT(a_stall_blocks, clk, rst_n, out_valid && !out_ready |-> !in_ready)
  // reset empties the result register
  `GHLP_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid)

endmodule

bind gzip_header_length_parser_top ghlp_checker u_ghlp_checker (.*);

// ===== test/tb_gzip_header_length_parser_top.sv =====
// Testbench: gzip header length parser, table rows with typed results, random buffers checked by a predictor.
`timescale 1ns / 1ps
module tb_gzip_header_length_parser_top;
  import ghlp_pkg::*;

  localparam int LENGTH_BITS = 16;
  localparam int HDR_LIMIT =
    ((longint'(1) << LENGTH_BITS) - 1 > 65535) ? 65535 : int'((longint'(1) << LENGTH_BITS) - 1);
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int PHASE_BYTES = 475;

  typedef enum logic [3:0] {
    HP_MAGIC0, HP_MAGIC1, HP_FIXED, HP_XLO, HP_XHI, HP_EXTRA,
    HP_NAME, HP_COMMENT, HP_CRC0, HP_CRC1, HP_DONE, HP_IGNORE
  } hdr_phase_t;

  typedef struct {
    logic [7:0]  value;
    logic        is_last;
    bit          typed;
    logic [15:0] len;
    status_t     st;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        in_byte_value;
  logic              in_last_byte;
  logic              out_valid;
  logic              out_ready;
  logic [HLEN_W-1:0] out_header_length;
  logic [1:0]        out_status;

  hdr_phase_t  hdr_phase;
  logic [15:0] hdr_pos;
  logic [7:0]  hdr_flags;
  logic [15:0] xtra_left;
  logic [7:0]  xtra_lo;
  bit          hdr_decided;

  result_t     header_results_q[$];
  logic [7:0]  frame_q[$];
  bit          row_typed;
  result_t     row_res;
  int          idle_pct;
  int          stall_pct;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  dir_row_t dir_rows[22] = '{
    '{8'h00, 1'b1, 1'b1, 16'd0, ST_BAD_MAGIC},
    '{MAGIC0, 1'b0, 1'b0, 16'd0, ST_OK},
    '{MAGIC1, 1'b1, 1'b1, 16'd0, ST_BAD_MAGIC},
    '{MAGIC0, 1'b0, 1'b0, 16'd0, ST_OK},
    '{MAGIC1, 1'b0, 1'b0, 16'd0, ST_OK},
    '{8'h08, 1'b0, 1'b0, 16'd0, ST_OK},
    '{8'hff, 1'b0, 1'b0, 16'd0, ST_OK},
    '{8'h00, 1'b0, 1'b0, 16'd0, ST_OK},
    '{8'h00, 1'b0, 1'b0, 16'd0, ST_OK},
    '{8'h00, 1'b0, 1'b0, 16'd0, ST_OK},
    '{8'h00, 1'b0, 1'b0, 16'd0, ST_OK},
    '{8'h00, 1'b0, 1'b0, 16'd0, ST_OK},
    '{8'hff, 1'b0, 1'b0, 16'd0, ST_OK},
    '{8'h00, 1'b0, 1'b0, 16'd0, ST_OK},
    '{8'h00, 1'b0, 1'b0, 16'd0, ST_OK},
    '{8'h00, 1'b0, 1'b0, 16'd0, ST_OK},
    '{8'h00, 1'b0, 1'b0, 16'd0, ST_OK},
    '{8'hff, 1'b0, 1'b0, 16'd0, ST_OK},
    '{8'hff, 1'b1, 1'b1, 16'd16, ST_OK},
    '{MAGIC0, 1'b0, 1'b0, 16'd0, ST_OK},
    '{8'hff, 1'b0, 1'b1, 16'd0, ST_BAD_MAGIC},
    '{8'haa, 1'b1, 1'b0, 16'd0, ST_OK}
  };

  gzip_header_length_parser_top #(
    .LENGTH_BITS(LENGTH_BITS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_value    (in_byte_value),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_header_length(out_header_length),
    .out_status       (out_status)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void clear_parser();
    hdr_phase   = HP_MAGIC0;
    hdr_pos     = '0;
    hdr_flags   = '0;
    xtra_left   = '0;
    xtra_lo     = '0;
    hdr_decided = 1'b0;
  endfunction

  function automatic hdr_phase_t next_part(input hdr_phase_t from);
    if (from <= HP_XLO && (hdr_flags & F_EXTRA) != 0) return HP_XLO;
    if (from <= HP_NAME && (hdr_flags & F_NAME) != 0) return HP_NAME;
    if (from <= HP_COMMENT && (hdr_flags & F_COMMENT) != 0) return HP_COMMENT;
    if (from <= HP_CRC0 && (hdr_flags & F_HCRC) != 0) return HP_CRC0;
    return HP_DONE;
  endfunction

  function automatic bit parse_header_byte(input logic [7:0] value, input logic is_last,
                                           output result_t res);
    int n;
    bit bad;
    bit hit;
    n = int'(hdr_pos) + 1;
    if (n > HDR_LIMIT) n = HDR_LIMIT;
    bad = 1'b0;
    hit = 1'b0;
    res = '0;
    if (hdr_decided || hdr_phase == HP_IGNORE) begin
      if (is_last) clear_parser();
      return 1'b0;
    end
    case (hdr_phase)
      HP_MAGIC0: begin
        if (value != MAGIC0) bad = 1'b1;
        else hdr_phase = HP_MAGIC1;
      end
      HP_MAGIC1: begin
        if (value != MAGIC1) bad = 1'b1;
        else hdr_phase = HP_FIXED;
      end
      HP_FIXED: begin
        if (n == FLAG_POS) hdr_flags = value;
        if (n >= FIXED_LEN) hdr_phase = next_part(HP_XLO);
      end
      HP_XLO: begin
        xtra_lo   = value;
        hdr_phase = HP_XHI;
      end
      HP_XHI: begin
        xtra_left = {value, xtra_lo};
        hdr_phase = (xtra_left != 0) ? HP_EXTRA : next_part(HP_NAME);
      end
      HP_EXTRA: begin
        xtra_left = xtra_left - 16'd1;
        if (xtra_left == 0) hdr_phase = next_part(HP_NAME);
      end
      HP_NAME: begin
        if (value == 8'h00) hdr_phase = next_part(HP_COMMENT);
      end
      HP_COMMENT: begin
        if (value == 8'h00) hdr_phase = next_part(HP_CRC0);
      end
      HP_CRC0: hdr_phase = HP_CRC1;
      HP_CRC1: hdr_phase = HP_DONE;
      default: begin
        hdr_phase = HP_IGNORE;
        if (is_last) clear_parser();
        return 1'b0;
      end
    endcase
    hdr_pos = n[15:0];
    if (bad) begin
      res.status = ST_BAD_MAGIC;
      hit = 1'b1;
    end else if (hdr_phase == HP_DONE) begin
      res.header_length = n[15:0];
      res.status = ST_OK;
      hit = 1'b1;
    end else if (n >= HDR_LIMIT) begin
      res.status = ST_TOO_LONG;
      hit = 1'b1;
    end else if (is_last) begin
      res.status = (n < FIXED_LEN) ? ST_BAD_MAGIC : ST_TRUNC;
      hit = 1'b1;
    end
    if (hit) begin
      hdr_decided = 1'b1;
      hdr_phase   = HP_IGNORE;
    end
    if (is_last) clear_parser();
    return hit;
  endfunction

  // Prediction on accepted requests, then result checking.
  always @(posedge clk) begin
    result_t pred;
    result_t want;
    bit      got;
    if (!rst_n) begin
      clear_parser();
      header_results_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        got = parse_header_byte(in_byte_value, in_last_byte, pred);
        if (row_typed) header_results_q.push_back(row_res);
        else if (got) header_results_q.push_back(pred);
      end
      if (out_valid && out_ready) begin
        if (header_results_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: len %0d status %0d", out_header_length, out_status);
        end else begin
          want = header_results_q.pop_front();
          if (out_header_length !== want.header_length || out_status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected len %0d status %0d, got len %0d status %0d",
                       want.header_length, want.status, out_header_length, out_status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(input logic [7:0] value, input logic is_last,
                           input bit typed, input result_t typed_res);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_byte_value = value;
    in_last_byte  = is_last;
    row_typed     = typed;
    row_res       = typed_res;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++)
      send_item(frame_q[i], i == frame_q.size() - 1, 1'b0, '0);
  endtask

  task automatic build_frame(output int core);
    int         kind;
    int         xlen;
    int         cut;
    int         idx;
    logic [7:0] flg;
    frame_q.delete();
    kind = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 14)) frame_q.push_back(8'($urandom));
      core = frame_q.size();
    end else begin
      flg = 8'($urandom);
      frame_q = '{MAGIC0, MAGIC1, 8'($urandom), flg};
      repeat (6) frame_q.push_back(8'($urandom));
      if ((flg & F_EXTRA) != 0) begin
        xlen = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4);
        frame_q.push_back(xlen[7:0]);
        frame_q.push_back(xlen[15:8]);
        repeat (xlen) frame_q.push_back(8'($urandom));
      end
      if ((flg & F_NAME) != 0) begin
        repeat ($urandom_range(0, 6)) frame_q.push_back(8'($urandom_range(1, 255)));
        frame_q.push_back(8'h00);
      end
      if ((flg & F_COMMENT) != 0) begin
        repeat ($urandom_range(0, 6)) frame_q.push_back(8'($urandom_range(1, 255)));
        frame_q.push_back(8'h00);
      end
      if ((flg & F_HCRC) != 0) repeat (2) frame_q.push_back(8'($urandom));
      core = frame_q.size();
      if (kind < 20) begin
        idx = $urandom_range(0, 1);
        frame_q[idx] = frame_q[idx] ^ 8'($urandom_range(1, 255));
      end else if (kind < 35) begin
        cut = $urandom_range(1, core);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
        core = cut;
      end
      repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom));
    end
  endtask

  initial begin
    int core;
    int sent;
    result_t typed_res;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_byte_value  = '0;
    in_last_byte   = 1'b0;
    row_typed      = 1'b0;
    row_res        = '0;
    idle_pct       = 0;
    stall_pct      = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      typed_res.header_length = dir_rows[i].len;
      typed_res.status        = dir_rows[i].st;
      send_item(dir_rows[i].value, dir_rows[i].is_last, dir_rows[i].typed, typed_res);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_frame(core);
        send_frame();
        sent += core;
      end
    end
    in_valid = 1'b0;

    while (header_results_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && header_results_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
